FILE: rtl/core/rsss_pkg.sv
`timescale 1ns / 1ps

package rsss_pkg;

    localparam int SPAN_W   = 10;              // register span width
    localparam int COLOR_W  = 8;
    localparam int POS_W    = 11;              // running destination position
    localparam int IDX_W    = 11;              // source pixel counter
    localparam int ERR_W    = 13;              // signed error accumulator
    localparam int ADJ_W    = 11;              // 2 * remainder, 2 * span
    localparam int DIV_STEPS = SPAN_W;         // one quotient bit per step
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_DEST_SPAN   = 2'd0;
    localparam logic [1:0] REG_SOURCE_SPAN = 2'd1;
    localparam logic [1:0] REG_TRANSPARENT = 2'd2;

    typedef enum logic [1:0] {
        K_FIRST,
        K_MIDDLE,
        K_LAST
    } t_kind;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               visible;
        t_kind              kind;
    } t_job;

    // per-line step values from the setup divider
    typedef struct packed {
        logic [SPAN_W-1:0]        whole_step;
        logic [SPAN_W-1:0]        init_count;
        logic [SPAN_W-1:0]        last_count;
        logic [ADJ_W-1:0]         adj_up;
        logic [ADJ_W-1:0]         adj_down;
        logic signed [ERR_W-1:0]  err_init;
    } t_steps;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_FIN
    } t_setup_state;

endpackage

FILE: rtl/core/rsss_setup.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle, then derives the step values.
module rsss_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rsss_pkg::SPAN_W-1:0]   i_xd,
    input  logic [rsss_pkg::SPAN_W-1:0]   i_yd,
    output logic                          o_busy,
    output rsss_pkg::t_steps              o_steps
);

    rsss_pkg::t_setup_state r_state, n_state;
    logic [rsss_pkg::SPAN_W-1:0]    r_num, r_quo, r_rem, r_den;
    logic [rsss_pkg::DIV_CNT_W-1:0] r_cnt;
    rsss_pkg::t_steps               r_steps;

    logic load_en, step_en, fin_en;
    logic [rsss_pkg::SPAN_W:0] trial;
    logic                      q_bit;
    logic                      div_last;

    assign trial    = {r_rem, r_num[rsss_pkg::SPAN_W-1]};
    assign q_bit    = (trial >= {1'b0, r_den});
    assign div_last = (r_cnt == rsss_pkg::DIV_CNT_W'(rsss_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsss_pkg::S_IDLE: if (i_start) n_state = rsss_pkg::S_LOAD;
            rsss_pkg::S_LOAD: n_state = rsss_pkg::S_DIV;
            rsss_pkg::S_DIV: begin
                if (i_start)       n_state = rsss_pkg::S_LOAD;
                else if (div_last) n_state = rsss_pkg::S_FIN;
            end
            rsss_pkg::S_FIN: n_state = i_start ? rsss_pkg::S_LOAD : rsss_pkg::S_IDLE;
            default: n_state = rsss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy  = 1'b1;
        load_en = 1'b0;
        step_en = 1'b0;
        fin_en  = 1'b0;
        unique case (r_state)
            rsss_pkg::S_IDLE: o_busy  = 1'b0;
            rsss_pkg::S_LOAD: load_en = 1'b1;
            rsss_pkg::S_DIV:  step_en = 1'b1;
            rsss_pkg::S_FIN:  fin_en  = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsss_pkg::S_LOAD;    // derive reset values after reset
        end else begin
            r_state <= n_state;
        end
    end

    // final step values
    logic                            even_exact;
    logic signed [rsss_pkg::ERR_W-1:0] err_calc;

    assign even_exact = (r_rem == '0) && !r_quo[0];
    assign err_calc   = $signed({3'b000, r_rem})
                      - $signed({2'b00, r_den, 1'b0})
                      + (r_quo[0] ? $signed({3'b000, r_den}) : '0);

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_num <= i_xd;
            r_den <= i_yd;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (step_en) begin
            r_num <= {r_num[rsss_pkg::SPAN_W-2:0], 1'b0};
            r_rem <= q_bit ? rsss_pkg::SPAN_W'(trial - {1'b0, r_den})
                           : trial[rsss_pkg::SPAN_W-1:0];
            r_quo <= {r_quo[rsss_pkg::SPAN_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (fin_en) begin
            r_steps.whole_step <= r_quo;
            r_steps.last_count <= {1'b0, r_quo[rsss_pkg::SPAN_W-1:1]} + 1'b1;
            r_steps.init_count <= {1'b0, r_quo[rsss_pkg::SPAN_W-1:1]}
                                  + (even_exact ? 1'b0 : 1'b1);
            r_steps.adj_up     <= {r_rem, 1'b0};
            r_steps.adj_down   <= {r_den, 1'b0};
            r_steps.err_init   <= err_calc;
        end
    end

    assign o_steps = r_steps;

endmodule

FILE: rtl/core/rsss_front.sv
`timescale 1ns / 1ps

// Takes source pixels, tracks place in the line, tags first/middle/last.
module rsss_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_abort,
    input  logic                           i_busy,
    input  logic [rsss_pkg::SPAN_W-1:0]    i_yd,
    input  logic [rsss_pkg::COLOR_W-1:0]   i_transparent,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rsss_pkg::COLOR_W-1:0]   i_pixel,
    input  logic                           i_q_full,
    output logic                           o_push,
    output rsss_pkg::t_job                 o_job
);

    logic [rsss_pkg::IDX_W-1:0] r_idx, n_idx;
    logic accept, short_span, is_last;

    assign o_ready    = !i_busy && !i_q_full;
    assign accept     = i_valid && o_ready;
    assign short_span = (i_yd < rsss_pkg::SPAN_W'(2));
    assign is_last    = (r_idx >= {1'b0, i_yd});

    always_comb begin
        o_job.color   = i_pixel;
        o_job.visible = (i_pixel != i_transparent);
        if (r_idx == '0)  o_job.kind = rsss_pkg::K_FIRST;
        else if (is_last) o_job.kind = rsss_pkg::K_LAST;
        else              o_job.kind = rsss_pkg::K_MIDDLE;
    end

    assign o_push = accept && !short_span;

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            if (short_span || (is_last && r_idx != '0)) n_idx = '0;
            else                                         n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_abort) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

FILE: rtl/core/rsss_queue.sv
`timescale 1ns / 1ps

// Short job queue between front and back.
module rsss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rsss_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rsss_pkg::t_job o_job
);

    localparam int PTR_W = $clog2(rsss_pkg::QUEUE_DEPTH);

    rsss_pkg::t_job r_mem [rsss_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(rsss_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

FILE: rtl/core/rsss_back.sv
`timescale 1ns / 1ps

// Works out run length and start from the error term; output register.
module rsss_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsss_pkg::t_steps              i_steps,
    input  logic                          i_job_valid,
    input  rsss_pkg::t_job                i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rsss_pkg::COLOR_W-1:0]  o_color,
    output logic [rsss_pkg::SPAN_W-1:0]   o_start,
    output logic [rsss_pkg::SPAN_W-1:0]   o_length,
    output logic                          o_visible,
    output logic                          o_last
);

    logic                              r_valid;
    logic [rsss_pkg::POS_W-1:0]        r_pos, n_pos;
    logic signed [rsss_pkg::ERR_W-1:0] r_err, n_err;
    logic [rsss_pkg::COLOR_W-1:0]      r_color;
    logic [rsss_pkg::SPAN_W-1:0]       r_start, r_length;
    logic                              r_visible, r_last;

    logic [rsss_pkg::POS_W-1:0]        start;
    logic [rsss_pkg::SPAN_W-1:0]       len;
    logic signed [rsss_pkg::ERR_W-1:0] err_sum;

    assign o_pop   = i_job_valid && (!r_valid || i_ready);
    assign err_sum = r_err + $signed({2'b00, i_steps.adj_up});
    assign start   = (i_job.kind == rsss_pkg::K_FIRST) ? '0 : r_pos;

    always_comb begin
        len   = i_steps.init_count;
        n_err = r_err;
        n_pos = start + {1'b0, len};
        unique case (i_job.kind)
            rsss_pkg::K_FIRST: begin
                len   = i_steps.init_count;
                n_err = i_steps.err_init;
                n_pos = start + {1'b0, len};
            end
            rsss_pkg::K_MIDDLE: begin
                if (err_sum > 0) begin
                    len   = i_steps.whole_step + 1'b1;
                    n_err = err_sum - $signed({2'b00, i_steps.adj_down});
                end else begin
                    len   = i_steps.whole_step;
                    n_err = err_sum;
                end
                n_pos = start + {1'b0, len};
            end
            rsss_pkg::K_LAST: begin
                len   = i_steps.last_count;
                n_pos = '0;
            end
            default: begin
                len = i_steps.init_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pos     <= n_pos;
            r_err     <= n_err;
            r_color   <= i_job.color;
            r_start   <= start[rsss_pkg::SPAN_W-1:0];
            r_length  <= len;
            r_visible <= i_job.visible;
            r_last    <= (i_job.kind == rsss_pkg::K_LAST);
        end
    end

    assign o_valid   = r_valid;
    assign o_color   = r_color;
    assign o_start   = r_start;
    assign o_length  = r_length;
    assign o_visible = r_visible;
    assign o_last    = r_last;

endmodule

FILE: rtl/core/run_slice_scanline_stretch.sv
`timescale 1ns / 1ps

// Scanline stretcher: turns each source pixel beat into one run beat (colour,
// start, length, visible flag in tuser, tlast on the final run of the line)
// by run-length slice stepping. Throughput is one pixel a clock while m_tready
// stays high and the setup divider is idle. An accepted pixel's job is written
// to the job queue and its run then to the output register, where the run can
// be taken. After reset and after every write to dest_span, source_span or
// transparent_index, s_tready stays low while the setup divider (load, 10
// divide steps, finish) derives the whole step and error terms; any such
// write also restarts the line. A line is source_span+1 pixels. With
// source_span below two, pixels are consumed and give no run. Registers:
// dest_span at 0x0, source_span at 0x4, transparent_index at 0x8; pready is
// tied high.
module run_slice_scanline_stretch #(
    parameter int MAX_SPAN = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // source pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] source_pixel
    // runs
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [7:0] run_color, [17:8] run_start,
                                     // [27:18] run_length, [31:28] zero
    output logic        m_tlast,     // line_end
    output logic        m_tuser      // run_visible
);

    localparam logic [12:0] SPAN_LIM = 13'(MAX_SPAN - 1);

    // register file
    logic [rsss_pkg::SPAN_W-1:0]  r_dest_span, r_source_span;
    logic [rsss_pkg::COLOR_W-1:0] r_transparent;
    logic                         cfg_wr, cfg_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (paddr[3:2] == rsss_pkg::REG_DEST_SPAN
                             || paddr[3:2] == rsss_pkg::REG_SOURCE_SPAN
                             || paddr[3:2] == rsss_pkg::REG_TRANSPARENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_span   <= rsss_pkg::SPAN_W'(3);
            r_source_span <= rsss_pkg::SPAN_W'(2);
            r_transparent <= rsss_pkg::COLOR_W'(255);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rsss_pkg::REG_DEST_SPAN:   r_dest_span   <= pwdata[9:0];
                rsss_pkg::REG_SOURCE_SPAN: r_source_span <= pwdata[9:0];
                rsss_pkg::REG_TRANSPARENT: r_transparent <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rsss_pkg::REG_DEST_SPAN:   prdata = {22'd0, r_dest_span};
            rsss_pkg::REG_SOURCE_SPAN: prdata = {22'd0, r_source_span};
            rsss_pkg::REG_TRANSPARENT: prdata = {24'd0, r_transparent};
            default:                   prdata = '0;
        endcase
    end

    // spans clamped to the largest supported span
    logic [rsss_pkg::SPAN_W-1:0] xd, yd;
    assign xd = ({3'b000, r_dest_span} > SPAN_LIM)
              ? SPAN_LIM[rsss_pkg::SPAN_W-1:0] : r_dest_span;
    assign yd = ({3'b000, r_source_span} > SPAN_LIM)
              ? SPAN_LIM[rsss_pkg::SPAN_W-1:0] : r_source_span;

    logic             busy;
    rsss_pkg::t_steps steps;

    rsss_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_hit),
        .i_xd    (xd),
        .i_yd    (yd),
        .o_busy  (busy),
        .o_steps (steps)
    );

    logic           q_full, q_push, q_pop, q_valid;
    rsss_pkg::t_job f_job, q_job;

    rsss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_abort       (cfg_hit),
        .i_busy        (busy),
        .i_yd          (yd),
        .i_transparent (r_transparent),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_pixel       (s_tdata),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (f_job)
    );

    rsss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    logic [rsss_pkg::COLOR_W-1:0] run_color;
    logic [rsss_pkg::SPAN_W-1:0]  run_start, run_length;

    rsss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_steps     (steps),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_color     (run_color),
        .o_start     (run_start),
        .o_length    (run_length),
        .o_visible   (m_tuser),
        .o_last      (m_tlast)
    );

    assign m_tdata = {4'd0, run_length, run_start, run_color};

endmodule

FILE: rtl/core/rsss_checker.sv
`timescale 1ns / 1ps

module rsss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled run beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("run beat changed while stalled");

    // a register write starts the setup pass, so pixels are held off
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite
         && (paddr[3:2] == rsss_pkg::REG_DEST_SPAN
          || paddr[3:2] == rsss_pkg::REG_SOURCE_SPAN
          || paddr[3:2] == rsss_pkg::REG_TRANSPARENT)) |=> !s_tready)
        else $error("pixel taken straight after register write");

    // setup pass runs out of reset
    a_boot_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !s_tready)
        else $error("pixel taken before step values derived");

    // pad bits of tdata stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[31:28] == 4'd0))
        else $error("tdata pad bits set");

endmodule

bind run_slice_scanline_stretch rsss_checker u_rsss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/run_slice_scanline_stretch_tb.sv
`timescale 1ns / 1ps

// Stretcher bench: pixel beats in on the slave side, run beats checked on the
// master side against a local model of the slice stepping, registers set over
// APB between phases with the pipe drained.
module run_slice_scanline_stretch_tb;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int IDLE_PCT    = 31;   // chance of an idle cycle on either side
    localparam int SETTLE      = 8;    // clocks allowed after the last run
    localparam logic [1:0] REG_UNMAPPED = 2'd3;   // beyond the register map

    // one expected run beat
    typedef struct packed {
        logic [7:0] color;
        logic [9:0] start;
        logic [9:0] length;
        logic       visible;
        logic       line_end;
    } t_run_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] source_pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] run_color, [17:8] run_start, [27:18] run_length
    logic        m_tlast;           // line_end
    logic        m_tuser;           // run_visible

    run_slice_scanline_stretch uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stretch model: register copies and per-line stepping state
    // ------------------------------------------------------------------
    int unsigned dest_span_q, source_span_q;
    logic [7:0]  transp_q;
    int          err_acc;
    int unsigned pix_count, dest_pos, whole_step, first_len, adj_up;

    logic [7:0]  pixels_pending[$];     // pixel beats waiting for the driver
    t_run_beat   runs_due[$];           // expected run beats, oldest first
    int          errors = 0;
    bit          steady = 1'b0;         // no idling on either side while set
    int          cycles = 0;

    function automatic void derive_steps();
        int unsigned rem;
        rem        = dest_span_q % source_span_q;
        whole_step = dest_span_q / source_span_q;
        adj_up     = rem * 2;
        err_acc    = int'(rem) - int'(source_span_q * 2);
        first_len  = whole_step / 2 + 1;
        // even step, no fraction: the spare pixel goes to the last run
        if (adj_up == 0 && (whole_step & 1) == 0)
            first_len--;
        if ((whole_step & 1) != 0)
            err_acc += int'(source_span_q);
    endfunction

    function automatic void restart_line();
        pix_count = 0;
        dest_pos  = 0;
        if (source_span_q >= 2)
            derive_steps();
    endfunction

    function automatic void stretch_pixel(input logic [7:0] px);
        int unsigned len;
        t_run_beat   rb;
        logic        last;
        last = 1'b0;
        // short source span: pixel swallowed, line held at its start
        if (source_span_q < 2) begin
            pix_count = 0;
            dest_pos  = 0;
            return;
        end
        if (pix_count == 0)
            derive_steps();
        if (pix_count == 0) begin
            len = first_len;
        end else if (pix_count >= source_span_q) begin
            len  = (adj_up == 0 && (whole_step & 1) == 0) ? first_len + 1 : first_len;
            last = 1'b1;
        end else begin
            len = whole_step;
            err_acc += int'(adj_up);
            if (err_acc > 0) begin
                len++;
                err_acc -= int'(source_span_q * 2);
            end
        end
        rb.color    = px;
        rb.start    = dest_pos[9:0];       // wraps modulo 1024
        rb.length   = len[9:0];
        rb.visible  = (px != transp_q);
        rb.line_end = last;
        runs_due.push_back(rb);
        if (last) begin
            pix_count = 0;
            dest_pos  = 0;
        end else begin
            pix_count = (pix_count + 1) & 11'h7FF;
            dest_pos  = (dest_pos + len) & 11'h7FF;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: beat held until taken, random gaps between beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                stretch_pixel(s_tdata);
                void'(pixels_pending.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pixels_pending.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixels_pending[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Run monitor: random back-pressure, each run beat against the oldest
    // expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_run_beat rb;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (runs_due.size() == 0) begin
                    errors++;
                    $error("run beat with none expected: tdata %h last %b user %b",
                           m_tdata, m_tlast, m_tuser);
                end else begin
                    rb = runs_due.pop_front();
                    check_field("run_color",   rb.color,    m_tdata[7:0]);
                    check_field("run_start",   rb.start,    m_tdata[17:8]);
                    check_field("run_length",  rb.length,   m_tdata[27:18]);
                    check_field("run_visible", rb.visible,  m_tuser);
                    check_field("line_end",    rb.line_end, m_tlast);
                end
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("run_slice_scanline_stretch_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);      // access edge: write lands, read data valid
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write then read back; any mapped write restarts the line
    task automatic cfg_write(input logic [1:0] idx, input int unsigned value);
        logic [31:0] rd;
        logic [31:0] want;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            rsss_pkg::REG_DEST_SPAN: begin
                dest_span_q = value & 10'h3FF;
                want = dest_span_q;
            end
            rsss_pkg::REG_SOURCE_SPAN: begin
                source_span_q = value & 10'h3FF;
                want = source_span_q;
            end
            rsss_pkg::REG_TRANSPARENT: begin
                transp_q = value[7:0];
                want = transp_q;
            end
            default: return;    // unmapped: no effect on the line
        endcase
        restart_line();
        apb_access(1'b0, idx, 32'h0, rd);
        check_field("prdata", want, rd);
    endtask

    task automatic feed(input logic [7:0] px);
        pixels_pending.push_back(px);
    endtask

    // hold until every pixel is taken and every run has come back
    task automatic drain();
        while (pixels_pending.size() != 0 || s_tvalid || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned d, s, n, r, phase, total;
        logic [7:0]  px;

        dest_span_q   = 3;
        source_span_q = 2;
        transp_q      = 8'hFF;
        restart_line();

        @(posedge i_clk iff i_rst_n);

        // reset spans: one full line then the start of the next
        feed(8'h00); feed(8'hFF); feed(8'h5A); feed(8'hFF);
        drain();

        // widest destination, colour 0 transparent
        cfg_write(rsss_pkg::REG_DEST_SPAN, 1023);
        cfg_write(rsss_pkg::REG_TRANSPARENT, 0);
        feed(8'h00); feed(8'hFF); feed(8'h80);
        drain();

        // source span below two: pixels swallowed, no runs
        cfg_write(rsss_pkg::REG_SOURCE_SPAN, 0);
        feed(8'h33); feed(8'hCC);
        drain();
        cfg_write(rsss_pkg::REG_SOURCE_SPAN, 1);
        feed(8'h0F);
        drain();

        // destination narrower than source, zero-length runs
        cfg_write(rsss_pkg::REG_DEST_SPAN, 0);
        cfg_write(rsss_pkg::REG_SOURCE_SPAN, 3);
        feed(8'h01); feed(8'h02); feed(8'h04); feed(8'h08);
        drain();

        // line cut short by a register write
        cfg_write(rsss_pkg::REG_DEST_SPAN, 11);
        cfg_write(rsss_pkg::REG_SOURCE_SPAN, 4);
        feed(8'h10); feed(8'h20);
        drain();
        cfg_write(rsss_pkg::REG_TRANSPARENT, 8'h42);
        feed(8'h42); feed(8'h40); feed(8'h7F); feed(8'hFE); feed(8'h42);
        drain();

        // unmapped write mid-line must not disturb the line
        feed(8'h11); feed(8'h22);
        drain();
        cfg_write(REG_UNMAPPED, 32'h3FF);
        feed(8'h33); feed(8'h44); feed(8'h55);
        drain();

        // random phases
        total = 0;
        phase = 0;
        while (total < 2000) begin
            phase++;
            r = $urandom_range(99);
            if (phase == 3) begin
                d = 1023; s = 1022;                     // one full-width line
            end else if (r < 5 && phase != 5) begin
                s = $urandom_range(1, 0); d = $urandom_range(1023, 0);
            end else if (r < 15) begin
                s = $urandom_range(40, 2); d = $urandom_range(s, 0);
            end else if (r < 25) begin
                s = $urandom_range(12, 2); d = $urandom_range(1023, 1000);
            end else begin
                s = $urandom_range(12, 2);
                d = $urandom_range(4 * s + 20, s + 1);
            end
            if ($urandom_range(1, 0) != 0) begin
                cfg_write(rsss_pkg::REG_SOURCE_SPAN, s);
                cfg_write(rsss_pkg::REG_DEST_SPAN, d);
            end else begin
                cfg_write(rsss_pkg::REG_DEST_SPAN, d);
                cfg_write(rsss_pkg::REG_SOURCE_SPAN, s);
            end
            if ($urandom_range(1, 0) != 0)
                cfg_write(rsss_pkg::REG_TRANSPARENT, $urandom_range(255, 0));
            if ($urandom_range(19, 0) == 0)
                cfg_write(REG_UNMAPPED, $urandom());

            // lines, often plus a partial one, cut by the next phase's writes
            if (s < 2)
                n = $urandom_range(6, 2);
            else if (phase == 3)
                n = s + 1;
            else if (phase == 5)
                n = (s + 1) * 20;
            else
                n = (s + 1) * $urandom_range(4, 1) + $urandom_range(s, 0);

            steady = (phase == 5);
            for (int unsigned k = 0; k < n; k++) begin
                px = ($urandom_range(4, 0) == 0) ? transp_q : 8'($urandom_range(255, 0));
                feed(px);
            end
            drain();
            steady = 1'b0;
            total += n;
        end

        drain();
        if (runs_due.size() != 0) begin
            errors++;
            $error("%0d run beats never arrived", runs_due.size());
        end
        if (errors == 0)
            $display("run_slice_scanline_stretch_tb: clean");
        else
            $display("run_slice_scanline_stretch_tb: errors");
        $finish;
    end

endmodule
